// ===== rtl/global_alignment_scorer_assert.svh =====
// Assertion macros used by the alignment scorer checker.
`ifndef GLOBAL_ALIGNMENT_SCORER_ASSERT_SVH
`define GLOBAL_ALIGNMENT_SCORER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define GAS_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, muted while rst_ni is low.
`define GAS_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gas_pkg.sv =====
// Types, codes and saturation helpers of the global alignment scorer.
package gas_pkg;

  localparam int WIDE_W    = 20;
  localparam int SCORE_W   = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic signed [WIDE_W-1:0]  wide_t;
  typedef logic signed [SCORE_W-1:0] score_t;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP      = 2'd2;

  localparam wide_t SCORE_MAX = 20'sd32767;
  localparam wide_t SCORE_MIN = -20'sd32768;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_SOURCE = 2'd1,
    FUNC_TRACE  = 2'd2,
    FUNC_SCORE  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KIND_SCORE = 2'd0,
    KIND_TRACE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    DIR_PAIR   = 2'd0,
    DIR_INSERT = 2'd1,
    DIR_REMOVE = 2'd2
  } dir_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW_INIT,
    ST_ROW_PRIME,
    ST_ROW_RUN,
    ST_ROW_DONE,
    ST_TRACE_RD,
    ST_TRACE_GET,
    ST_SCORE_RD,
    ST_SCORE_GET,
    ST_EMIT
  } state_e;

  function automatic wide_t ext8(logic signed [7:0] v);
    return {{(WIDE_W-8){v[7]}}, v};
  endfunction

  function automatic wide_t ext16(score_t v);
    return {{(WIDE_W-SCORE_W){v[SCORE_W-1]}}, v};
  endfunction

  function automatic score_t sat16(wide_t v);
    score_t r;
    if (v > SCORE_MAX) begin
      r = 16'sh7FFF;
    end else if (v < SCORE_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/global_alignment_scorer.sv =====
// Needleman-Wunsch global alignment scorer with linear gap cost.
//
// Input channel (in_valid_i / in_ready_o) carries one transaction per request:
//   load reference symbol, source symbol, trace read, score report.
// Output channel (out_valid_o / out_ready_i) carries score, trace and error
// results; a reference load, and a source symbol past the row limit, give none.
// Configuration: cfg_we_i writes match, mismatch or gap score.
// Each request is finished before the next is accepted; in_ready_o is high only
//   in the idle state. A reference load is written there. A trace read passes
//   a read and a get state (an out-of-range one skips the get), a score report
//   a read and a get state, a source symbol row init, prime, run over its columns
//   and row done (one dropped at the row limit stays idle); results then go
//   through an emit state and are offered as the block becomes ready again.
// A source row is paced by the score row memory: one column is read, scored
// and written back per cycle, so the row time grows with the reference length.
// Results leave through an output register. When the receiver stalls the
// block finishes its current request and, if it gives a result, waits with
// in_ready_o low until the register is free.
// Reset clears the reference length, the row count and the output valid and
// loads the default scores; the memories need no clearing pass.
module global_alignment_scorer #(
  parameter int MAX_REF_LEN = 64,
  parameter int MAX_SRC_LEN = 64,
  localparam int ROW_W = $clog2(MAX_SRC_LEN + 1),
  localparam int COL_W = $clog2(MAX_REF_LEN + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [gas_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [7:0]                     cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [1:0]                     func_i,
  input  logic                           start_new_i,
  input  logic [7:0]                     symbol_i,
  input  logic [ROW_W-1:0]               row_index_i,
  input  logic [COL_W-1:0]               col_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [1:0]                     result_kind_o,
  output logic signed [15:0]             align_score_o,
  output logic [1:0]                     trace_dir_o
);
  import gas_pkg::*;

  localparam int NCOLS  = MAX_REF_LEN + 1;
  localparam int NCELLS = (MAX_SRC_LEN + 1) * NCOLS;
  localparam int REF_AW = (MAX_REF_LEN > 1) ? $clog2(MAX_REF_LEN) : 1;
  localparam int DIR_AW = $clog2(NCELLS);
  localparam logic [DIR_AW-1:0] NCOLS_A  = DIR_AW'(NCOLS);
  localparam logic [ROW_W-1:0]  SRC_MAX  = ROW_W'(MAX_SRC_LEN);
  localparam logic [COL_W-1:0]  REF_MAX  = COL_W'(MAX_REF_LEN);

  // Configuration registers
  logic signed [7:0] match_q, mismatch_q, gap_q;

  // Control state
  state_e            state_q, state_d;
  logic [ROW_W-1:0]  rows_q;       // rows computed since the last restart
  logic [COL_W-1:0]  ref_len_q;
  logic [DIR_AW-1:0] base_q;       // direction address of column 0 of the next row
  logic              out_valid_q;

  // Working registers
  logic [7:0]        sym_q;
  logic [ROW_W-1:0]  ri_q;
  logic [COL_W-1:0]  ci_q;
  logic [COL_W-1:0]  col_q;
  score_t            diag_q;       // previous row, column c-1
  score_t            left_q;       // current row, column c-1
  wide_t             acc_q;        // c * gap, for the implicit row zero
  kind_e             res_kind_q, out_kind_q;
  score_t            res_score_q, out_score_q;
  dir_e              res_dir_q, out_dir_q;

  // Memories
  logic [7:0]        ref_mem [MAX_REF_LEN];
  score_t            sc_mem  [NCOLS];
  logic [1:0]        dir_mem [NCELLS];
  logic [7:0]        ref_rdata_q;
  score_t            sc_rdata_q;
  logic [1:0]        dir_rdata_q;

  // Memory controls
  logic              ref_we;
  logic [REF_AW-1:0] ref_waddr, ref_raddr;
  logic              sc_we;
  logic [COL_W-1:0]  sc_waddr, sc_raddr;
  score_t            sc_wdata;
  logic              dir_we;
  logic [DIR_AW-1:0] dir_waddr, dir_raddr;

  // Misc combinational
  logic              in_acc, acc_load, src_full, trace_oor, out_load, row_zero;
  logic [ROW_W-1:0]  rows_p1;
  logic [COL_W-1:0]  ref_len_next;
  wide_t             gap_w, mul_a, mul_p;
  score_t            prev_c, cell_score;
  wide_t             sig_w, pair_w, ins_w, rem_w, best_w;
  dir_e              cell_dir, trace_val;

  assign in_acc   = in_valid_i && in_ready_o;
  assign acc_load = in_acc && (func_e'(func_i) == FUNC_LOAD);
  assign src_full = (rows_q >= SRC_MAX);
  assign row_zero = (rows_q == '0);
  assign rows_p1  = rows_q + 1'b1;
  assign trace_oor = (ri_q > rows_q) || (ci_q > ref_len_q);
  assign ref_len_next = (start_new_i ? '0 : ref_len_q) + 1'b1;
  assign gap_w    = ext8(gap_q);

  // One shared multiplier: row number or reference length times gap
  assign mul_a = (state_q == ST_ROW_INIT) ? {{(WIDE_W-ROW_W){1'b0}}, rows_p1}
                                          : {{(WIDE_W-COL_W){1'b0}}, ref_len_q};
  assign mul_p = mul_a * gap_w;

  // Cell update
  always_comb begin
    prev_c = row_zero ? sat16(acc_q) : sc_rdata_q;
    sig_w  = (ref_rdata_q == sym_q) ? ext8(match_q) : ext8(mismatch_q);
    pair_w = ext16(diag_q) + sig_w;
    ins_w  = ext16(prev_c) + gap_w;
    rem_w  = ext16(left_q) + gap_w;
    best_w = pair_w;
    if (ins_w > best_w) begin
      best_w = ins_w;
    end
    if (rem_w > best_w) begin
      best_w = rem_w;
    end
    if (ins_w > pair_w) begin
      cell_dir = (ins_w > rem_w) ? DIR_INSERT : DIR_REMOVE;
    end else begin
      cell_dir = (rem_w > pair_w) ? DIR_REMOVE : DIR_PAIR;
    end
    cell_score = sat16(best_w);
  end

  // Edges of the matrix are fixed; inner cells come from the store
  always_comb begin
    if (ri_q == '0) begin
      trace_val = DIR_REMOVE;
    end else if (ci_q == '0) begin
      trace_val = DIR_INSERT;
    end else begin
      trace_val = dir_e'(dir_rdata_q);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (func_e'(func_i))
            FUNC_SOURCE: state_d = src_full ? ST_IDLE : ST_ROW_INIT;
            FUNC_TRACE:  state_d = ST_TRACE_RD;
            FUNC_SCORE:  state_d = ST_SCORE_RD;
            default:     state_d = ST_IDLE;
          endcase
        end
      end
      ST_ROW_INIT:  state_d = ST_ROW_PRIME;
      ST_ROW_PRIME: state_d = (ref_len_q == '0) ? ST_ROW_DONE : ST_ROW_RUN;
      ST_ROW_RUN:   state_d = (col_q == ref_len_q) ? ST_ROW_DONE : ST_ROW_RUN;
      ST_ROW_DONE:  state_d = ST_EMIT;
      ST_TRACE_RD:  state_d = trace_oor ? ST_EMIT : ST_TRACE_GET;
      ST_TRACE_GET: state_d = ST_EMIT;
      ST_SCORE_RD:  state_d = ST_SCORE_GET;
      ST_SCORE_GET: state_d = ST_EMIT;
      ST_EMIT:      state_d = (!out_valid_q || out_ready_i) ? ST_IDLE : ST_EMIT;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    out_load   = 1'b0;
    ref_we     = 1'b0;
    ref_waddr  = start_new_i ? '0 : ref_len_q[REF_AW-1:0];
    ref_raddr  = '0;
    sc_we      = 1'b0;
    sc_waddr   = '0;
    sc_wdata   = cell_score;
    sc_raddr   = '0;
    dir_we     = 1'b0;
    dir_waddr  = base_q + DIR_AW'(col_q);
    dir_raddr  = DIR_AW'(ri_q) * NCOLS_A + DIR_AW'(ci_q);
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        ref_we     = acc_load && (start_new_i || (row_zero && (ref_len_q < REF_MAX)));
      end
      ST_ROW_INIT: begin
        sc_we    = 1'b1;
        sc_wdata = sat16(mul_p);
      end
      ST_ROW_PRIME: begin
        sc_raddr = COL_W'(1);
      end
      ST_ROW_RUN: begin
        sc_we     = 1'b1;
        sc_waddr  = col_q;
        dir_we    = 1'b1;
        sc_raddr  = col_q + 1'b1;
        ref_raddr = col_q[REF_AW-1:0];
      end
      ST_SCORE_RD: begin
        sc_raddr = ref_len_q;
      end
      ST_EMIT: begin
        out_load = !out_valid_q || out_ready_i;
      end
      default: begin
      end
    endcase
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= symbol_i;
    end
    ref_rdata_q <= ref_mem[ref_raddr];
  end

  // Column c is written while column c+1 is read, so no overlap within a row
  always_ff @(posedge clk_i) begin
    if (sc_we) begin
      sc_mem[sc_waddr] <= sc_wdata;
    end
    sc_rdata_q <= sc_mem[sc_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dir_we) begin
      dir_mem[dir_waddr] <= cell_dir;
    end
    dir_rdata_q <= dir_mem[dir_raddr];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rows_q      <= '0;
      ref_len_q   <= '0;
      base_q      <= NCOLS_A;
      out_valid_q <= 1'b0;
      match_q     <= 8'sd1;
      mismatch_q  <= -8'sd1;
      gap_q       <= -8'sd1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MATCH:    match_q    <= cfg_data_i;
          REG_MISMATCH: mismatch_q <= cfg_data_i;
          REG_GAP:      gap_q      <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (acc_load && start_new_i) begin
        rows_q <= '0;
        base_q <= NCOLS_A;
      end else if (state_q == ST_ROW_DONE) begin
        rows_q <= rows_p1;
        base_q <= base_q + NCOLS_A;
      end
      if (ref_we) begin
        ref_len_q <= ref_len_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q <= symbol_i;
      ri_q  <= row_index_i;
      ci_q  <= col_index_i;
    end
    case (state_q)
      ST_ROW_INIT: begin
        left_q <= sat16(mul_p);
      end
      ST_ROW_PRIME: begin
        diag_q <= row_zero ? '0 : sc_rdata_q;
        acc_q  <= gap_w;
        col_q  <= COL_W'(1);
      end
      ST_ROW_RUN: begin
        diag_q <= prev_c;
        left_q <= cell_score;
        acc_q  <= acc_q + gap_w;
        col_q  <= col_q + 1'b1;
      end
      ST_ROW_DONE: begin
        res_kind_q  <= KIND_SCORE;
        res_score_q <= left_q;
        res_dir_q   <= DIR_PAIR;
      end
      ST_TRACE_RD: begin
        res_kind_q  <= KIND_ERROR;
        res_score_q <= '0;
        res_dir_q   <= DIR_PAIR;
      end
      ST_TRACE_GET: begin
        res_kind_q  <= KIND_TRACE;
        res_score_q <= '0;
        res_dir_q   <= trace_val;
      end
      ST_SCORE_GET: begin
        res_kind_q  <= KIND_SCORE;
        res_score_q <= row_zero ? sat16(mul_p) : sc_rdata_q;
        res_dir_q   <= DIR_PAIR;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_kind_q  <= res_kind_q;
      out_score_q <= res_score_q;
      out_dir_q   <= res_dir_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = out_kind_q;
  assign align_score_o = out_score_q;
  assign trace_dir_o   = out_dir_q;

endmodule

// ===== rtl/gas_checker.sv =====
// Port-level checker for the global alignment scorer, with its bind.
`include "global_alignment_scorer_assert.svh"

module gas_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [1:0]          func_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [1:0]          result_kind_o,
  input logic signed [15:0]  align_score_o,
  input logic [1:0]          trace_dir_o
);
  import gas_pkg::*;

  logic take_rd;
  assign take_rd = in_valid_i && in_ready_o &&
                   ((func_i == FUNC_TRACE) || (func_i == FUNC_SCORE));

  // A trace or score transaction always occupies the block for a while
  `GAS_ASSERT_NEXT(a_busy_after_read, take_rd, !in_ready_o, "ready after read request")
  // Only trace results carry a direction
  `GAS_ASSERT_NOW(a_dir_zero, out_valid_o && (result_kind_o != KIND_TRACE), trace_dir_o == DIR_PAIR, "direction on non-trace result")
  // Only score results carry a score
  `GAS_ASSERT_NOW(a_score_zero, out_valid_o && (result_kind_o != KIND_SCORE), align_score_o == '0, "score on non-score result")
  // Stalled result holds
  `GAS_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(align_score_o) && $stable(result_kind_o) && $stable(trace_dir_o), "stalled result changed")

endmodule

bind global_alignment_scorer gas_checker u_gas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .func_i        (func_i),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .result_kind_o (result_kind_o),
  .align_score_o (align_score_o),
  .trace_dir_o   (trace_dir_o)
);
